[rtl/core/cwt_pkg.sv]
// Shared constants, codes and state types of the cellular texture engine.
package cwt_pkg;

  localparam int MAX_DENSITY_DEF     = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int MAX_TEX_SIZE_DEF    = 4096;

  localparam int DENS_W     = 5;
  localparam int TEX_W      = 13;
  localparam int PAT_W      = 2;
  localparam int PIX_W      = 12;
  localparam int IDX_W      = 8;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // reciprocal of five in Q.16, exact for quotients below 1300
  localparam int RECIP5_W = 14;
  localparam logic [RECIP5_W-1:0] RECIP5 = 14'd13108;
  localparam int RECIP5_SH = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DENSITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR     = 3'd5;

  localparam logic [PAT_W-1:0] PAT_CROSS = 2'd0;
  localparam logic [PAT_W-1:0] PAT_CONE  = 2'd1;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_NB_RD,
    S_NB_SQX,
    S_NB_SQY,
    S_NB_ROOT,
    S_NB_WAIT,
    S_PAT,
    S_CLAMP,
    S_SH1,
    S_SH2,
    S_OUT
  } cwt_state_e;

  typedef enum logic [2:0] {
    DIV_PX,
    DIV_PY,
    DIV_XO,
    DIV_YO,
    DIV_XM,
    DIV_YM
  } cwt_div_sel_e;

endpackage

[rtl/core/cwt_if.sv]
// Valid/ready channels for load/pixel items and shaded RGBA results.
interface cwt_in_if #(parameter int PT_W = 18);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [7:0]             point_index;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic [11:0]            pixel_x;
  logic [11:0]            pixel_y;
  modport source (output valid, mode, point_index, point_x, point_y, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, mode, point_index, point_x, point_y, pixel_x, pixel_y,
                output ready);
endinterface

interface cwt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

[rtl/core/cwt_ram.sv]
// Generic single write port RAM with registered read.
module cwt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/core/cwt_div.sv]
// Restoring divider, one quotient bit per cycle, quotient and remainder.
module cwt_div #(
  parameter int NW = 28,
  parameter int DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);
  localparam int CW = $clog2(NW);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DW:0]   sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh     = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = DW'(sh - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = sh[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

[rtl/core/cwt_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module cwt_isqrt #(
  parameter int SQ_W = 60
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   val_i,
  output logic              done_o,
  output logic [SQ_W/2-1:0] root_o
);
  localparam int STEPS = SQ_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SQ_W-1:0] v_q, v_d, r_q, r_d, b_q, b_d, rb;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    rb     = r_q + b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = val_i;
      r_d    = '0;
      b_d    = {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d   = b_q >> 2;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[SQ_W/2-1:0];
endmodule

[rtl/core/cellular_worley_texture.sv]
// Top level: Worley F1/F2 cellular texture engine with shared divider and square root.
//
//   channel | dir | transfer when          | payload
//   in_if   | in  | in_if.valid & ready    | mode, point_index, point_x/y, pixel_x/y
//   out_if  | out | out_if.valid & ready   | red, green, blue, alpha
//   cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A load is a single RAM write. A pixel runs six serial divisions in the shared divider
// and nine serial square roots.
// Reset returns control and configuration to their defaults; the point table is undefined until loaded.
// The input is ready only when idle; a finished pixel waits in the output register.
module cellular_worley_texture #(
  parameter int COORD_FRAC_BITS = cwt_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cwt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cwt_in_if.sink                         in_if,
  cwt_out_if.source                      out_if
);
  import cwt_pkg::*;

  localparam int MAX_DENSITY  = MAX_DENSITY_DEF;
  localparam int MAX_TEX_SIZE = MAX_TEX_SIZE_DEF;

  localparam int F     = COORD_FRAC_BITS;
  localparam int PT_W  = F + 2;
  localparam int NW    = PIX_W + F;
  localparam int AX_W  = NW + 1;
  localparam int SQ_W  = 2 * AX_W + 2;
  localparam int RT_W  = SQ_W / 2;
  localparam int FW    = F + 4;
  localparam int TD    = MAX_DENSITY * MAX_DENSITY;
  localparam int AW    = $clog2(TD);
  localparam int XD_W  = PIX_W + DENS_W;
  localparam int WD_W  = TEX_W + DENS_W;
  localparam int PW    = FW + DENS_W;
  localparam int VW    = PW + 2;
  localparam int SPW   = F + CH_W + 2;
  localparam int NSW   = F + 11;
  localparam int DX_W  = NW + 2;

  localparam logic signed [VW-1:0]   ONE_V  = {{(VW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [PT_W:0]   ONE_C  = {2'b00, 1'b1, {F{1'b0}}};
  localparam logic [FW-1:0]          F_INIT = FW'(10) << F;

  // configuration
  logic [DENS_W-1:0] dens_q;
  logic [TEX_W-1:0]  texw_q, texh_q;
  logic [PAT_W-1:0]  pat_q;
  logic              cmode_q;
  logic [31:0]       colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dens_q   <= DENS_W'(8);
      texw_q   <= TEX_W'(256);
      texh_q   <= TEX_W'(256);
      pat_q    <= PAT_W'(2);
      cmode_q  <= 1'b0;
      colour_q <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DENSITY:    dens_q   <= cfg_data_i[DENS_W-1:0];
        REG_TEX_WIDTH:  texw_q   <= cfg_data_i[TEX_W-1:0];
        REG_TEX_HEIGHT: texh_q   <= cfg_data_i[TEX_W-1:0];
        REG_PATTERN:    pat_q    <= cfg_data_i[PAT_W-1:0];
        REG_CELL_MODE:  cmode_q  <= cfg_data_i[0];
        REG_COLOUR:     colour_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [DENS_W-1:0] d_eff;
  logic [TEX_W-1:0]  w_eff, h_eff;

  always_comb begin
    if (dens_q == '0) d_eff = DENS_W'(1);
    else if (32'(dens_q) > 32'(MAX_DENSITY)) d_eff = DENS_W'(MAX_DENSITY);
    else d_eff = dens_q;
    if (texw_q == '0) w_eff = TEX_W'(1);
    else if (32'(texw_q) > 32'(MAX_TEX_SIZE)) w_eff = TEX_W'(MAX_TEX_SIZE);
    else w_eff = texw_q;
    if (texh_q == '0) h_eff = TEX_W'(1);
    else if (32'(texh_q) > 32'(MAX_TEX_SIZE)) h_eff = TEX_W'(MAX_TEX_SIZE);
    else h_eff = texh_q;
  end

  // sequencer state and datapath registers
  cwt_state_e   state_q, state_d;
  cwt_div_sel_e sel_q;
  logic [1:0]   nu_q, nv_q, ch_q;

  logic [PIX_W-1:0]  x_q, y_q;
  logic [XD_W-1:0]   xd_q, yd_q, xo_q, yo_q;
  logic              x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic [NW-1:0]     px_q, py_q;
  logic [DENS_W-1:0] xm_q, ym_q;
  logic [SQ_W-1:0]   sq_q;
  logic [AX_W-1:0]   ay_q;
  logic [FW-1:0]     f1_q, f2_q;
  logic [PW-1:0]     pp_q;
  logic [F:0]        v_q;
  logic [SPW-1:0]    sp_q;
  logic [CH_W-1:0]   shade_q [3];
  logic              out_valid_q;
  logic [CH_W-1:0]   red_q, green_q, blue_q, alpha_q;

  logic in_xfer, out_free, last_nb;
  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;
  assign last_nb  = (nu_q == 2'd2) && (nv_q == 2'd2);

  // shared units
  logic              div_start, div_done;
  logic [NW-1:0]     div_num, div_quo;
  logic [TEX_W-1:0]  div_den, div_rem;
  logic              sq_start, sq_done;
  logic [RT_W-1:0]   root;

  cwt_div #(.NW(NW), .DW(TEX_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  cwt_isqrt #(.SQ_W(SQ_W)) u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_q), .done_o(sq_done), .root_o(root)
  );

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [2*PT_W-1:0] ram_rdata;

  assign ram_we    = in_xfer && (in_if.mode == MODE_LOAD)
                     && (32'(in_if.point_index) < 32'(TD));
  assign ram_waddr = AW'(in_if.point_index);

  cwt_ram #(.WIDTH(2*PT_W), .DEPTH(TD)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i({in_if.point_x, in_if.point_y}),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_xfer && in_if.mode != MODE_LOAD) state_d = S_SETUP;
      S_SETUP:    state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_d = (sel_q == DIV_YM) ? S_NB_RD : S_DIV_GO;
      S_NB_RD:    state_d = S_NB_SQX;
      S_NB_SQX:   state_d = S_NB_SQY;
      S_NB_SQY:   state_d = S_NB_ROOT;
      S_NB_ROOT:  state_d = S_NB_WAIT;
      S_NB_WAIT:  if (sq_done) state_d = last_nb ? S_PAT : S_NB_RD;
      S_PAT:      state_d = S_CLAMP;
      S_CLAMP:    state_d = S_SH1;
      S_SH1:      state_d = S_SH2;
      S_SH2:      state_d = (ch_q == 2'd2) ? S_OUT : S_SH1;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready = (state_q == S_IDLE);
    div_start   = (state_q == S_DIV_GO);
    sq_start    = (state_q == S_NB_ROOT);
    ram_re      = (state_q == S_NB_RD);
  end

  // divider operands
  always_comb begin
    unique case (sel_q)
      DIV_PX:  begin div_num = {x_q, {F{1'b0}}}; div_den = w_eff; end
      DIV_PY:  begin div_num = {y_q, {F{1'b0}}}; div_den = h_eff; end
      DIV_XO:  begin div_num = NW'(xd_q);        div_den = w_eff; end
      DIV_YO:  begin div_num = NW'(yd_q);        div_den = h_eff; end
      DIV_XM:  begin div_num = NW'(xo_q);        div_den = TEX_W'(d_eff); end
      DIV_YM:  begin div_num = NW'(yo_q);        div_den = TEX_W'(d_eff); end
      default: begin div_num = '0;               div_den = TEX_W'(1); end
    endcase
  end

  // neighbour address with wrap
  logic [DENS_W-1:0]   col, row, d_m1;
  logic [2*DENS_W-1:0] idx;

  assign d_m1 = d_eff - DENS_W'(1);

  always_comb begin
    unique case (nu_q)
      2'd0:    col = (xm_q == '0) ? d_m1 : xm_q - DENS_W'(1);
      2'd2:    col = (xm_q == d_m1) ? '0 : xm_q + DENS_W'(1);
      default: col = xm_q;
    endcase
    unique case (nv_q)
      2'd0:    row = (ym_q == '0) ? d_m1 : ym_q - DENS_W'(1);
      2'd2:    row = (ym_q == d_m1) ? '0 : ym_q + DENS_W'(1);
      default: row = ym_q;
    endcase
    idx = (2*DENS_W)'(col) + (2*DENS_W)'(row) * (2*DENS_W)'(d_eff);
  end

  assign ram_raddr = AW'(idx);

  // distance of one neighbour
  logic signed [PT_W:0]   cx, cy;
  logic signed [DX_W-1:0] dx, dy;
  logic [AX_W-1:0]        ax, ay;

  always_comb begin
    cx = {ram_rdata[2*PT_W-1], ram_rdata[2*PT_W-1:PT_W]};
    cy = {ram_rdata[PT_W-1], ram_rdata[PT_W-1:0]};
    if (nu_q == 2'd0 && x_lo_q) cx = cx - ONE_C;
    if (nu_q == 2'd2 && x_hi_q) cx = cx + ONE_C;
    if (nv_q == 2'd0 && y_lo_q) cy = cy - ONE_C;
    if (nv_q == 2'd2 && y_hi_q) cy = cy + ONE_C;
    dx = $signed({2'b00, px_q}) - DX_W'(cx);
    dy = $signed({2'b00, py_q}) - DX_W'(cy);
    ax = dx[DX_W-1] ? AX_W'(-dx) : AX_W'(dx);
    ay = dy[DX_W-1] ? AX_W'(-dy) : AX_W'(dy);
  end

  // pattern value
  logic [FW-1:0]          pat_op;
  logic signed [VW-1:0]   pps, v_raw;

  always_comb begin
    unique case (pat_q)
      PAT_CROSS: pat_op = f2_q;
      PAT_CONE:  pat_op = f1_q;
      default:   pat_op = f2_q - f1_q;
    endcase
    pps = $signed(VW'(pp_q));
    unique case (pat_q)
      PAT_CROSS: v_raw = (pps <<< 1) - ONE_V;
      PAT_CONE:  v_raw = ONE_V - pps;
      default:   v_raw = pps;
    endcase
  end

  // shading of one channel
  logic [CH_W-1:0]         chan_c;
  logic [F+CH_W:0]         vc;
  logic [NSW-1:0]          sh_n;
  logic [10:0]             sh_t;
  logic [10+RECIP5_W:0]    sh_q5;
  logic [CH_W-1:0]         sh_byte;
  logic                    odd;

  assign odd = xo_q[0] ^ yo_q[0];

  always_comb begin
    unique case (ch_q)
      2'd0:    chan_c = colour_q[31:24];
      2'd1:    chan_c = colour_q[23:16];
      default: chan_c = colour_q[15:8];
    endcase
    vc = (F+CH_W+1)'(v_q) * (F+CH_W+1)'(chan_c);
    if (cmode_q && odd) begin
      // c*(5 - 2v): five times the tint minus the doubled product
      sh_n = (NSW'(11'(chan_c) * 11'd5) << F) - NSW'(sp_q);
    end else begin
      sh_n = NSW'(sp_q);
    end
    sh_t  = sh_n[NSW-1:F];
    sh_q5 = (11+RECIP5_W)'(sh_t) * (11+RECIP5_W)'(RECIP5);
    if (cmode_q) sh_byte = sh_q5[RECIP5_SH+CH_W-1:RECIP5_SH];
    else sh_byte = sh_t[CH_W-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= DIV_PX;
      nu_q        <= '0;
      nv_q        <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_SETUP: sel_q <= DIV_PX;
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (sel_q)
              DIV_PX:  sel_q <= DIV_PY;
              DIV_PY:  sel_q <= DIV_XO;
              DIV_XO:  sel_q <= DIV_YO;
              DIV_YO:  sel_q <= DIV_XM;
              DIV_XM:  sel_q <= DIV_YM;
              default: sel_q <= DIV_PX;
            endcase
            nu_q <= '0;
            nv_q <= '0;
          end
        end
        S_NB_WAIT: begin
          if (sq_done) begin
            if (nu_q == 2'd2) begin
              nu_q <= '0;
              nv_q <= nv_q + 2'd1;
            end else begin
              nu_q <= nu_q + 2'd1;
            end
          end
        end
        S_CLAMP: ch_q <= '0;
        S_SH2:   ch_q <= ch_q + 2'd1;
        default: ;
      endcase
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          x_q <= in_if.pixel_x;
          y_q <= in_if.pixel_y;
        end
      end
      S_SETUP: begin
        xd_q   <= XD_W'(x_q) * XD_W'(d_eff);
        yd_q   <= XD_W'(y_q) * XD_W'(d_eff);
        x_lo_q <= (XD_W'(x_q) * XD_W'(d_eff)) < XD_W'(w_eff);
        y_lo_q <= (XD_W'(y_q) * XD_W'(d_eff)) < XD_W'(h_eff);
        x_hi_q <= WD_W'(XD_W'(x_q) * XD_W'(d_eff)) >= WD_W'(w_eff) * WD_W'(d_m1);
        y_hi_q <= WD_W'(XD_W'(y_q) * XD_W'(d_eff)) >= WD_W'(h_eff) * WD_W'(d_m1);
        f1_q   <= F_INIT;
        f2_q   <= F_INIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel_q)
            DIV_PX:  px_q <= div_quo;
            DIV_PY:  py_q <= div_quo;
            DIV_XO:  xo_q <= div_quo[XD_W-1:0];
            DIV_YO:  yo_q <= div_quo[XD_W-1:0];
            DIV_XM:  xm_q <= div_rem[DENS_W-1:0];
            default: ym_q <= div_rem[DENS_W-1:0];
          endcase
        end
      end
      S_NB_SQX: begin
        sq_q <= SQ_W'(ax * ax);
        ay_q <= ay;
      end
      S_NB_SQY: sq_q <= sq_q + SQ_W'(ay_q * ay_q);
      S_NB_WAIT: begin
        if (sq_done) begin
          if (root < RT_W'(f1_q)) begin
            f2_q <= f1_q;
            f1_q <= root[FW-1:0];
          end else if (root < RT_W'(f2_q)) begin
            f2_q <= root[FW-1:0];
          end
        end
      end
      S_PAT: pp_q <= PW'(pat_op) * PW'(d_eff);
      S_CLAMP: begin
        if (v_raw < 0) v_q <= '0;
        else if (v_raw > ONE_V) v_q <= ONE_V[F:0];
        else v_q <= v_raw[F:0];
      end
      S_SH1: sp_q <= cmode_q ? {vc, 1'b0} : {1'b0, vc};
      S_SH2: shade_q[ch_q] <= sh_byte;
      S_OUT: begin
        if (out_free) begin
          red_q   <= shade_q[0];
          green_q <= shade_q[1];
          blue_q  <= shade_q[2];
          alpha_q <= colour_q[7:0];
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid = out_valid_q;
  assign out_if.red   = red_q;
  assign out_if.green = green_q;
  assign out_if.blue  = blue_q;
  assign out_if.alpha = alpha_q;
endmodule

[sim/testbench.sv]
// Self-checking testbench for the cellular texture engine: loads, pixels, config sweeps.
module testbench;
  import cwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_FX     = 64'd65536;
  localparam int              TABLE_SIZE = 256;
  localparam longint          CYCLE_CAP  = 4000000;

  typedef struct {
    logic                mode;
    logic [7:0]          index;
    logic signed [17:0]  pt_x;
    logic signed [17:0]  pt_y;
    logic [11:0]         pix_x;
    logic [11:0]         pix_y;
  } item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cwt_in_if #(.PT_W(18)) in_ch ();
  cwt_out_if             out_ch ();

  cellular_worley_texture DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  // shadow of the block's registers and point table
  logic [4:0]         sh_density;
  logic [12:0]        sh_width;
  logic [12:0]        sh_height;
  logic [1:0]         sh_pattern;
  logic               sh_chess;
  logic [31:0]        sh_colour;
  logic signed [17:0] pts_x [TABLE_SIZE];
  logic signed [17:0] pts_y [TABLE_SIZE];

  rgba_t  pixel_q[$];
  int     errors;
  int     src_idle;
  int     snk_idle = 0;
  int     hold_left = 0;
  longint cycles = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [7:0] tint(input longint unsigned c, input longint unsigned v,
                                      input logic odd);
    longint unsigned den;
    den = 5 * ONE_FX;
    if (!sh_chess) return 8'((v * c) >> 16);
    if (!odd) return 8'((2 * v * c) / den);
    return 8'((c * (den - 2 * v)) / den);
  endfunction

  function automatic rgba_t shade_pixel(input logic [11:0] xi, input logic [11:0] yi);
    longint unsigned d, w, h, x, y, xo, yo, row, col, idx, ax, ay;
    longint px, py, f1, f2, v, cx, cy, dx, dy, dlen;
    logic odd;
    rgba_t o;
    d = (sh_density == 0) ? 1 : (sh_density > 16) ? 16 : sh_density;
    w = (sh_width == 0) ? 1 : (sh_width > 4096) ? 4096 : sh_width;
    h = (sh_height == 0) ? 1 : (sh_height > 4096) ? 4096 : sh_height;
    x = xi;
    y = yi;
    px = longint'((x << 16) / w);
    py = longint'((y << 16) / h);
    xo = x * d / w;
    yo = y * d / h;
    f1 = 10 * ONE_FX;
    f2 = f1;
    for (int dv = 0; dv < 3; dv++) begin
      row = ((yo + d - 1 + dv) % d) * d;
      for (int du = 0; du < 3; du++) begin
        col = (xo + d - 1 + du) % d;
        idx = col + row;
        cx = pts_x[idx];
        cy = pts_y[idx];
        // edge bands see the neighbor point across the wrap
        if (du == 0 && x * d < w) cx -= ONE_FX;
        if (dv == 0 && y * d < h) cy -= ONE_FX;
        if (du == 2 && x * d >= w * (d - 1)) cx += ONE_FX;
        if (dv == 2 && y * d >= h * (d - 1)) cy += ONE_FX;
        dx = px - cx;
        dy = py - cy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        dlen = longint'(root_floor(ax * ax + ay * ay));
        if (dlen < f1) begin
          f2 = f1;
          f1 = dlen;
        end else if (dlen < f2) begin
          f2 = dlen;
        end
      end
    end
    if (sh_pattern == PAT_CROSS) v = 2 * f2 * longint'(d) - longint'(ONE_FX);
    else if (sh_pattern == PAT_CONE) v = longint'(ONE_FX) - f1 * longint'(d);
    else v = (f2 - f1) * longint'(d);
    if (v < 0) v = 0;
    if (v > longint'(ONE_FX)) v = ONE_FX;
    odd = xo[0] ^ yo[0];
    o.red   = tint(sh_colour[31:24], v, odd);
    o.green = tint(sh_colour[23:16], v, odd);
    o.blue  = tint(sh_colour[15:8], v, odd);
    o.alpha = sh_colour[7:0];
    return o;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_DENSITY:    sh_density = data[4:0];
      REG_TEX_WIDTH:  sh_width   = data[12:0];
      REG_TEX_HEIGHT: sh_height  = data[12:0];
      REG_PATTERN:    sh_pattern = data[1:0];
      REG_CELL_MODE:  sh_chess   = data[0];
      REG_COLOUR:     sh_colour  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int dens, input int w, input int h, input int pat,
                           input int chess, input logic [31:0] col);
    write_reg(REG_DENSITY, dens);
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    write_reg(REG_PATTERN, pat);
    write_reg(REG_CELL_MODE, chess);
    write_reg(REG_COLOUR, col);
  endtask

  // valid stays high from one item to the next unless a gap is taken
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.point_index <= it.index;
    in_ch.point_x     <= it.pt_x;
    in_ch.point_y     <= it.pt_y;
    in_ch.pixel_x     <= it.pix_x;
    in_ch.pixel_y     <= it.pix_y;
    do @(posedge clk); while (!in_ch.ready);
    if (it.mode == MODE_LOAD) begin
      pts_x[it.index] = it.pt_x;
      pts_y[it.index] = it.pt_y;
    end else begin
      pixel_q.push_back(shade_pixel(it.pix_x, it.pix_y));
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_load(input int idx, input logic signed [17:0] x,
                           input logic signed [17:0] y);
    item_t it;
    it = '{MODE_LOAD, 8'(idx), x, y, 12'($urandom), 12'($urandom)};
    send_item(it);
  endtask

  task automatic send_pixel(input int x, input int y);
    item_t it;
    it = '{~MODE_LOAD, 8'($urandom), 18'($urandom), 18'($urandom), 12'(x), 12'(y)};
    send_item(it);
  endtask

  function automatic logic signed [17:0] rand_point();
    if ($urandom_range(9) == 0) return 18'($urandom);
    return 18'($urandom_range(65535));
  endfunction

  task automatic test_table_fill();
    for (int i = 0; i < TABLE_SIZE; i++) send_load(i, rand_point(), rand_point());
    settle();
  endtask

  task automatic test_directed();
    send_load(0, 18'sh1ffff, 18'sh20000);
    send_load(9, 18'sh20000, 18'sh1ffff);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(255, 0);
    settle();
    configure(1, 1, 1, PAT_CROSS, 0, 32'h80ff01ff);
    send_pixel(0, 0);
    send_pixel(3000, 17);
    settle();
    configure(16, 4096, 4096, PAT_CONE, 1, 32'hff000100);
    send_pixel(4095, 0);
    send_pixel(2048, 2304);
    settle();
    // out-of-range register values are clamped or aliased
    configure(0, 0, 8191, 3, 1, 32'h7f80c3a5);
    send_pixel(1, 4095);
    settle();
    configure(31, 8191, 0, 2, 0, 32'hffffffff);
    send_pixel(100, 200);
    send_pixel(4095, 1);
    settle();
    configure(5, 40, 24, PAT_CROSS, 1, 32'h12345678);
    send_pixel(39, 23);
    send_pixel(41, 30);
    send_pixel(8, 5);
    settle();
  endtask

  task automatic random_config();
    int w, h;
    w = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(1, 96);
    h = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(1, 96);
    configure(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16),
              w, h, $urandom_range(3), $urandom_range(1), $urandom);
  endtask

  task automatic test_random(input int count, input int sidle, input int ridle);
    int w, h;
    src_idle = sidle;
    snk_idle = ridle;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        settle();
        random_config();
      end
      w = (sh_width == 0) ? 1 : sh_width;
      h = (sh_height == 0) ? 1 : sh_height;
      if ($urandom_range(3) == 0)
        send_load($urandom_range(255), rand_point(), rand_point());
      else if ($urandom_range(7) == 0)
        send_pixel($urandom_range(4095), $urandom_range(4095));
      else
        send_pixel($urandom_range((w > 4096 ? 4096 : w) - 1),
                   $urandom_range((h > 4096 ? 4096 : h) - 1));
    end
    settle();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    @(posedge clk);
    hold_left <= 4000;
    for (int n = 0; n < 6; n++) send_pixel($urandom_range(255), $urandom_range(255));
    settle();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_ch.ready <= (hold_left <= 1) && ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    rgba_t exp_px;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        report("pixel transfer with nothing pending");
      end else begin
        exp_px = pixel_q.pop_front();
        if (out_ch.red !== exp_px.red)
          report($sformatf("red %0d, want %0d", out_ch.red, exp_px.red));
        if (out_ch.green !== exp_px.green)
          report($sformatf("green %0d, want %0d", out_ch.green, exp_px.green));
        if (out_ch.blue !== exp_px.blue)
          report($sformatf("blue %0d, want %0d", out_ch.blue, exp_px.blue));
        if (out_ch.alpha !== exp_px.alpha)
          report($sformatf("alpha %0d, want %0d", out_ch.alpha, exp_px.alpha));
      end
    end
  end

  initial begin
    errors    = 0;
    src_idle  = 0;
    sh_density = 8;
    sh_width   = 256;
    sh_height  = 256;
    sh_pattern = 2;
    sh_chess   = 0;
    sh_colour  = 32'hffffffff;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.point_index <= '0;
    in_ch.point_x     <= '0;
    in_ch.point_y     <= '0;
    in_ch.pixel_x     <= '0;
    in_ch.pixel_y     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_directed();
    test_random(400, 24, 78);
    test_random(400, 78, 24);
    test_random(400, 0, 0);
    test_backpressure();

    in_ch.valid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
